/* design/asc_pkg.sv */
// Package: widths, word types, microcode encoding and program ROM for the sensor calibrator.
`timescale 1ns / 1ps

package asc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 10;

  localparam int COEF_W    = 32;
  localparam int RC_W      = 11;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = SAMPLE_BITS + COUNT_BITS;
  localparam int SEEN_W    = COUNT_BITS + 1;
  localparam int CMP_W     = (RC_W > SEEN_W) ? RC_W : SEEN_W;
  localparam int FRAC_W    = 8;
  localparam int DVD_W     = SUM_W + FRAC_W;
  localparam int DCNT_W    = $clog2(DVD_W);
  localparam int X_W       = SAMPLE_BITS + FRAC_W;
  localparam int X2_W      = 2 * X_W;
  localparam int X2_SPLIT  = 20;
  localparam int X2_HI_W   = X2_W - X2_SPLIT;
  localparam int OPA_W     = COEF_W + 1;
  localparam int OPB_W     = (X2_HI_W > X_W) ? X2_HI_W : X_W;
  localparam int PROD_W    = OPA_W + OPB_W + 1;
  localparam int RES_W     = 64;
  localparam int PC_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_READING_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_SQUARE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_LINEAR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PH_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET   = 3'd5;

  localparam logic [RC_W-1:0] READING_COUNT_RST = 11'd16;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   channel;
    logic                   single;
  } in_word_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] value;
    logic                     result_channel;
    logic                     saturated;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_ACCUM,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_X_QUO,
    OP_X_SMP,
    OP_MUL_XX,
    OP_MUL_AHI,
    OP_MUL_ALO,
    OP_ADD_LO,
    OP_SHR_SQ,
    OP_MUL_LIN,
    OP_ADD_LIN,
    OP_ADD_OFF,
    OP_EMIT,
    OP_MUL_SLOPE,
    OP_SET_LIN
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SINGLE,
    C_NOT_REACHED,
    C_DIV_MORE,
    C_TEMP,
    C_OUT_BUSY
  } cond_e;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
  } ctrl_word_t;

  localparam pc_t S_WAIT   = 5'd0;
  localparam pc_t S_CHECK  = 5'd1;
  localparam pc_t S_ACCUM  = 5'd2;
  localparam pc_t S_TEST   = 5'd3;
  localparam pc_t S_LOAD   = 5'd4;
  localparam pc_t S_DIV    = 5'd5;
  localparam pc_t S_QUO    = 5'd6;
  localparam pc_t S_SINGLE = 5'd7;
  localparam pc_t S_CAL    = 5'd8;
  localparam pc_t S_AHI    = 5'd9;
  localparam pc_t S_ALO    = 5'd10;
  localparam pc_t S_ADDLO  = 5'd11;
  localparam pc_t S_SHRSQ  = 5'd12;
  localparam pc_t S_LIN    = 5'd13;
  localparam pc_t S_ADDLIN = 5'd14;
  localparam pc_t S_OFF    = 5'd15;
  localparam pc_t S_EMIT   = 5'd16;
  localparam pc_t S_DONE   = 5'd17;
  localparam pc_t S_TEMP   = 5'd18;
  localparam pc_t S_TLIN   = 5'd19;

  // Program ROM: jump to target when cond holds, else fall through.
  function automatic ctrl_word_t asc_ucode(pc_t pc);
    ctrl_word_t cw;
    cw = '{op: OP_NONE, cond: C_ALWAYS, target: S_WAIT};
    case (pc)
      S_WAIT:   cw = '{op: OP_LATCH,    cond: C_NO_INPUT,    target: S_WAIT};
      S_CHECK:  cw = '{op: OP_NONE,     cond: C_SINGLE,      target: S_SINGLE};
      S_ACCUM:  cw = '{op: OP_ACCUM,    cond: C_NEVER,       target: S_WAIT};
      S_TEST:   cw = '{op: OP_NONE,     cond: C_NOT_REACHED, target: S_WAIT};
      S_LOAD:   cw = '{op: OP_DIV_LOAD, cond: C_NEVER,       target: S_WAIT};
      S_DIV:    cw = '{op: OP_DIV_STEP, cond: C_DIV_MORE,    target: S_DIV};
      S_QUO:    cw = '{op: OP_X_QUO,    cond: C_ALWAYS,      target: S_CAL};
      S_SINGLE: cw = '{op: OP_X_SMP,    cond: C_NEVER,       target: S_WAIT};
      S_CAL:    cw = '{op: OP_MUL_XX,   cond: C_TEMP,        target: S_TEMP};
      S_AHI:    cw = '{op: OP_MUL_AHI,  cond: C_NEVER,       target: S_WAIT};
      S_ALO:    cw = '{op: OP_MUL_ALO,  cond: C_NEVER,       target: S_WAIT};
      S_ADDLO:  cw = '{op: OP_ADD_LO,   cond: C_NEVER,       target: S_WAIT};
      S_SHRSQ:  cw = '{op: OP_SHR_SQ,   cond: C_NEVER,       target: S_WAIT};
      S_LIN:    cw = '{op: OP_MUL_LIN,  cond: C_NEVER,       target: S_WAIT};
      S_ADDLIN: cw = '{op: OP_ADD_LIN,  cond: C_NEVER,       target: S_WAIT};
      S_OFF:    cw = '{op: OP_ADD_OFF,  cond: C_NEVER,       target: S_WAIT};
      S_EMIT:   cw = '{op: OP_EMIT,     cond: C_OUT_BUSY,    target: S_EMIT};
      S_DONE:   cw = '{op: OP_NONE,     cond: C_ALWAYS,      target: S_WAIT};
      S_TEMP:   cw = '{op: OP_MUL_SLOPE, cond: C_NEVER,      target: S_WAIT};
      S_TLIN:   cw = '{op: OP_SET_LIN,  cond: C_ALWAYS,      target: S_OFF};
      default:  cw = '{op: OP_NONE,     cond: C_ALWAYS,      target: S_WAIT};
    endcase
    return cw;
  endfunction

endpackage

/* design/averaged_sensor_calibrator_core.sv */
// Top level: microcoded sensor averager with serial divider and shared multiplier.
// A single-sample word goes straight to calibration; a word that completes an average first
// passes through the 30-step restoring divider. Calibration uses the shared 33x21 multiplier;
// the temperature channel takes a shorter path (slope and offset only).
// Throughput: one word per pass of the program; the input stalls until the result, if any,
// has been emitted, which waits on out_stall_i.
// Reset (asynchronous, active low): sums and counts cleared, reading count 16, coefficients 0.
`timescale 1ns / 1ps

module averaged_sensor_calibrator_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  asc_pkg::in_word_t                     in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output asc_pkg::out_word_t                    out_word_o,
  input  logic                                  cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [asc_pkg::COEF_W-1:0]            cfg_data_i
);
  import asc_pkg::*;

  logic [RC_W-1:0]          rc_q;
  logic signed [COEF_W-1:0] ph_sq_q, ph_lin_q, ph_off_q, t_slope_q, t_off_q;

  pc_t        pc_q, pc_d;
  ctrl_word_t cw;
  logic       jump;

  in_word_t          in_q;
  logic [SUM_W-1:0]  ph_sum_q, t_sum_q;
  logic [SEEN_W-1:0] ph_seen_q, t_seen_q;

  logic [DVD_W-1:0]  quo_q;
  logic [SEEN_W-1:0] rem_q, div_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [SEEN_W:0]   shifted;
  logic [SEEN_W+1:0] diff;

  logic [X_W-1:0]              x_q;
  logic [X2_SPLIT-1:0]         x2lo_q;
  logic signed [PROD_W-1:0]    p_q, mul_p;
  logic signed [OPA_W-1:0]     mul_a;
  logic [OPB_W-1:0]            mul_b;
  logic signed [RES_W-1:0]     res_q;
  logic signed [COEF_W-1:0]    off_sel;

  logic              out_valid_q;
  out_word_t         out_q;
  logic              out_free;

  logic [SUM_W-1:0]  sel_sum;
  logic [SEEN_W-1:0] sel_seen;
  logic [CMP_W-1:0]  eff, rc_ext;
  logic              reached;
  logic              in_accept;
  logic              overflow;

  assign in_stall_o  = (pc_q != S_WAIT);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign sel_sum  = in_q.channel ? t_sum_q : ph_sum_q;
  assign sel_seen = in_q.channel ? t_seen_q : ph_seen_q;

  always_comb begin
    rc_ext = CMP_W'(rc_q);
    if (rc_q == '0) begin
      eff = CMP_W'(1);
    end else if (rc_ext > CMP_W'(1 << COUNT_BITS)) begin
      eff = CMP_W'(1 << COUNT_BITS);
    end else begin
      eff = rc_ext;
    end
    reached = CMP_W'(sel_seen) >= eff;
  end

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, div_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.op)
      OP_MUL_XX: begin
        mul_a = $signed(OPA_W'(x_q));
        mul_b = OPB_W'(x_q);
      end
      OP_MUL_AHI: begin
        mul_a = OPA_W'(ph_sq_q);
        mul_b = OPB_W'(p_q[X2_W-1:X2_SPLIT]);
      end
      OP_MUL_ALO: begin
        mul_a = OPA_W'(ph_sq_q);
        mul_b = OPB_W'(x2lo_q);
      end
      OP_MUL_LIN: begin
        mul_a = OPA_W'(ph_lin_q);
        mul_b = OPB_W'(x_q);
      end
      OP_MUL_SLOPE: begin
        mul_a = OPA_W'(t_slope_q);
        mul_b = OPB_W'(x_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = mul_a * $signed({1'b0, mul_b});
  assign off_sel = in_q.channel ? t_off_q : ph_off_q;
  assign overflow = (res_q[RES_W-1:COEF_W-1] != '0) && (res_q[RES_W-1:COEF_W-1] != '1);

  // sequencer
  always_comb begin
    cw = asc_ucode(pc_q);
    case (cw.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_INPUT:    jump = !in_valid_i;
      C_SINGLE:      jump = in_q.single;
      C_NOT_REACHED: jump = !reached;
      C_DIV_MORE:    jump = (dcnt_q != '0);
      C_TEMP:        jump = in_q.channel;
      C_OUT_BUSY:    jump = !out_free;
      default:       jump = 1'b1;
    endcase
    pc_d = jump ? cw.target : pc_t'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q      <= READING_COUNT_RST;
      ph_sq_q   <= '0;
      ph_lin_q  <= '0;
      ph_off_q  <= '0;
      t_slope_q <= '0;
      t_off_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_READING_COUNT: rc_q      <= cfg_data_i[RC_W-1:0];
        CFG_PH_SQUARE:     ph_sq_q   <= cfg_data_i;
        CFG_PH_LINEAR:     ph_lin_q  <= cfg_data_i;
        CFG_PH_OFFSET:     ph_off_q  <= cfg_data_i;
        CFG_TEMP_SLOPE:    t_slope_q <= cfg_data_i;
        CFG_TEMP_OFFSET:   t_off_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_sum_q  <= '0;
      ph_seen_q <= '0;
      t_sum_q   <= '0;
      t_seen_q  <= '0;
    end else if (cw.op == OP_ACCUM) begin
      if (in_q.channel) begin
        t_sum_q  <= SUM_W'(t_sum_q + SUM_W'(in_q.sample));
        t_seen_q <= SEEN_W'(t_seen_q + 1'b1);
      end else begin
        ph_sum_q  <= SUM_W'(ph_sum_q + SUM_W'(in_q.sample));
        ph_seen_q <= SEEN_W'(ph_seen_q + 1'b1);
      end
    end else if (cw.op == OP_DIV_LOAD) begin
      if (in_q.channel) begin
        t_sum_q  <= '0;
        t_seen_q <= '0;
      end else begin
        ph_sum_q  <= '0;
        ph_seen_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cw.op == OP_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (cw.op)
      OP_LATCH: begin
        if (in_accept) begin
          in_q <= in_word_i;
        end
      end
      OP_DIV_LOAD: begin
        quo_q  <= {sel_sum, {FRAC_W{1'b0}}};
        div_q  <= sel_seen;
        rem_q  <= '0;
        dcnt_q <= DCNT_W'(DVD_W - 1);
      end
      OP_DIV_STEP: begin
        if (!diff[SEEN_W+1]) begin
          rem_q <= diff[SEEN_W-1:0];
          quo_q <= {quo_q[DVD_W-2:0], 1'b1};
        end else begin
          rem_q <= shifted[SEEN_W-1:0];
          quo_q <= {quo_q[DVD_W-2:0], 1'b0};
        end
        dcnt_q <= DCNT_W'(dcnt_q - 1'b1);
      end
      OP_X_QUO:   x_q <= quo_q[X_W-1:0];
      OP_X_SMP:   x_q <= {in_q.sample, {FRAC_W{1'b0}}};
      OP_MUL_XX:  p_q <= mul_p;
      OP_MUL_AHI: begin
        p_q    <= mul_p;
        x2lo_q <= p_q[X2_SPLIT-1:0];
      end
      OP_MUL_ALO: begin
        p_q   <= mul_p;
        res_q <= RES_W'(p_q);
      end
      OP_ADD_LO:    res_q <= res_q + RES_W'(p_q >>> X2_SPLIT);
      OP_SHR_SQ:    res_q <= res_q >>> X2_SPLIT;
      OP_MUL_LIN:   p_q <= mul_p;
      OP_ADD_LIN:   res_q <= res_q + RES_W'(p_q >>> 16);
      OP_MUL_SLOPE: p_q <= mul_p;
      OP_SET_LIN:   res_q <= RES_W'(p_q >>> 16);
      OP_ADD_OFF:   res_q <= res_q + RES_W'(off_sel);
      OP_EMIT: begin
        if (out_free) begin
          out_q.result_channel <= in_q.channel;
          out_q.saturated      <= overflow;
          if (!overflow) begin
            out_q.value <= res_q[COEF_W-1:0];
          end else if (res_q[RES_W-1]) begin
            out_q.value <= {1'b1, {(COEF_W-1){1'b0}}};
          end else begin
            out_q.value <= {1'b0, {(COEF_W-1){1'b1}}};
          end
        end
      end
      default: ;
    endcase
  end

endmodule
